FILE: design/jars_pkg.sv
// package for the job admission resource scheduler: types, constants, codes
`default_nettype none
package jars_pkg;
	localparam int MaxJobs = 32;
	localparam int HoldDepth = 32;
	localparam int SlotW = $clog2(MaxJobs);
	localparam int HoldW = $clog2(HoldDepth);
	localparam int CntW = 6;

	typedef enum logic [1:0] {
		REQ_NEW = 2'd0,
		REQ_DEVICE = 2'd1,
		REQ_RELEASE = 2'd2,
		REQ_UNKNOWN = 2'd3
	} req_kind_t;

	typedef enum logic [3:0] {
		OC_REJECTED = 4'd0,
		OC_HELD_SORTED = 4'd1,
		OC_HELD_FIFO = 4'd2,
		OC_READY = 4'd3,
		OC_BAD_PRIORITY = 4'd4,
		OC_GRANTED = 4'd5,
		OC_REQ_IGNORED = 4'd6,
		OC_RELEASED = 4'd7,
		OC_REL_IGNORED = 4'd8,
		OC_TABLE_FULL = 4'd9,
		OC_UNKNOWN_JOB = 4'd10
	} outcome_t;

	typedef enum logic [2:0] {
		ST_REJECTED = 3'd0,
		ST_HELD = 3'd1,
		ST_READY = 3'd2,
		ST_TERMINATED = 3'd3,
		ST_NONE = 3'd4
	} job_status_t;

	typedef enum logic [1:0] {
		CFG_TOTAL_MEMORY = 2'd0,
		CFG_TOTAL_DEVICES = 2'd1
	} cfg_index_t;

	localparam logic [1:0] PRI_SORTED = 2'd1;
	localparam logic [1:0] PRI_FIFO = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE,
		S_FIND_RD,
		S_FIND_CMP,
		S_SRT_RD,
		S_SRT_CMP,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_SRT_INS,
		S_FINISH
	} fsm_state_t;

	typedef struct packed {
		logic [1:0] req_type;
		logic [7:0] job_id;
		logic [9:0] mem_units;
		logic [7:0] max_demand;
		logic [15:0] run_time;
		logic [1:0] job_priority;
		logic [7:0] num_devices;
	} cmd_t;

	typedef struct packed {
		logic [3:0] outcome;
		logic [9:0] free_memory;
		logic [7:0] free_devices;
		logic [5:0] hold_sorted_count;
		logic [5:0] hold_fifo_count;
		logic [4:0] hold_position;
	} result_t;

	// job table row: id, mem, demand, granted, status
	typedef struct packed {
		logic [7:0] id;
		logic [9:0] mem;
		logic [7:0] demand;
		logic [7:0] granted;
		logic [2:0] status;
	} job_entry_t;

	typedef struct packed {
		logic [15:0] run_time;
		logic [SlotW-1:0] slot;
	} sorted_entry_t;
endpackage
`default_nettype wire

FILE: design/job_admission_resource_scheduler.sv
// top level of the job admission resource scheduler
`default_nettype none
// One command at a time: start is taken when busy is low, and the single result
// appears on result with done high for one cycle; the receiver cannot stall it.
// A new job that becomes ready, is rejected or goes to the fifo is settled in the finish state.
// Request and release walk the job table one entry at a time (one ram read
// and one compare state per entry) until the id matches or all n rows in the
// table have been read without a match.
// A priority-1 hold walks the sorted queue (a read and a compare state per
// entry up to the insertion point), then shifts the tail up one entry at a
// time (a read and a write state per entry) and writes the new entry at the
// insertion point through the single write port of that queue.
// Config writes load total and free counts and are only done while idle.
module job_admission_resource_scheduler
	import jars_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire cmd_t cmd,
	output logic done,
	output result_t result,
	input wire logic cfg_we,
	input wire logic [1:0] cfg_index,
	input wire logic [9:0] cfg_data
);
	fsm_state_t state_q, state_d;
	cmd_t cmd_q;
	logic [9:0] total_mem_q, avail_mem_q;
	logic [7:0] total_dev_q, avail_dev_q;
	logic [CntW-1:0] job_count_q, srt_len_q, fifo_len_q;
	logic [CntW-1:0] idx_q;
	logic [3:0] outcome_q;
	logic [HoldW-1:0] pos_q;
	logic done_q;

	// job table
	logic jt_we;
	logic [SlotW-1:0] jt_waddr, jt_raddr;
	job_entry_t jt_wdata, jt_rdata;
	// sorted hold queue
	logic sq_we;
	logic [HoldW-1:0] sq_waddr, sq_raddr;
	sorted_entry_t sq_wdata, sq_rdata;
	// fifo hold queue
	logic fq_we;

	jars_ram #(.Width($bits(job_entry_t)), .Depth(MaxJobs)) u_job_table (
		.clk(clk), .we(jt_we), .waddr(jt_waddr), .wdata(jt_wdata),
		.raddr(jt_raddr), .rdata(jt_rdata)
	);
	jars_ram #(.Width($bits(sorted_entry_t)), .Depth(HoldDepth)) u_sorted_q (
		.clk(clk), .we(sq_we), .waddr(sq_waddr), .wdata(sq_wdata),
		.raddr(sq_raddr), .rdata(sq_rdata)
	);
	logic [SlotW-1:0] fq_rdata;
	jars_ram #(.Width(SlotW), .Depth(HoldDepth)) u_fifo_q (
		.clk(clk), .we(fq_we), .waddr(fifo_len_q[HoldW-1:0]),
		.wdata(job_count_q[SlotW-1:0]), .raddr(fifo_len_q[HoldW-1:0]),
		.rdata(fq_rdata)
	);

	// a request is taken only when idle and no result is on the ports
	logic take;
	assign take = start && !done_q;

	// new-job classification from registered command
	logic table_full, too_big, fits, id_match;
	assign table_full = (job_count_q == CntW'(MaxJobs));
	assign too_big = (cmd_q.mem_units > total_mem_q) || (cmd_q.max_demand > total_dev_q);
	assign fits = (cmd_q.mem_units <= avail_mem_q);
	assign id_match = (jt_rdata.id == cmd_q.job_id);

	// adders for termination (memory) and release (devices), capped at total
	logic [10:0] mem_sum;
	logic [8:0] dev_sum;
	logic [7:0] grant;
	logic [7:0] dev_add;
	assign grant = (cmd_q.num_devices <= avail_dev_q) ? cmd_q.num_devices : avail_dev_q;
	// after granting and returning the grant, free devices are unchanged
	assign dev_add = (state_q == S_FIND_CMP && cmd_q.req_type == REQ_RELEASE)
		? cmd_q.num_devices : 8'd0;
	assign mem_sum = {1'b0, avail_mem_q} + {1'b0, jt_rdata.mem};
	assign dev_sum = {1'b0, avail_dev_q} + {1'b0, dev_add};

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (take) begin
					case (cmd.req_type)
						REQ_NEW: state_d = S_FINISH;
						REQ_DEVICE, REQ_RELEASE: state_d = S_FIND_RD;
						default: state_d = S_FINISH;
					endcase
				end
			end
			S_FIND_RD: begin
				if (idx_q == job_count_q) begin
					state_d = S_IDLE;
				end else begin
					state_d = S_FIND_CMP;
				end
			end
			S_FIND_CMP: state_d = id_match ? S_IDLE : S_FIND_RD;
			S_SRT_RD: state_d = (idx_q == srt_len_q) ? S_SHIFT_RD : S_SRT_CMP;
			S_SRT_CMP: state_d = (sq_rdata.run_time <= cmd_q.run_time) ? S_SRT_RD : S_SHIFT_RD;
			S_SHIFT_RD: state_d = (idx_q == {1'b0, pos_q}) ? S_SRT_INS : S_SHIFT_WR;
			S_SHIFT_WR: state_d = S_SHIFT_RD;
			S_SRT_INS: state_d = S_IDLE;
			S_FINISH: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
		// new job that must go to the sorted queue leaves finish for the walk
		if (state_q == S_FINISH && cmd_q.req_type == REQ_NEW && !table_full && !too_big
			&& !fits && cmd_q.job_priority == PRI_SORTED && srt_len_q != CntW'(HoldDepth)) begin
			state_d = S_SRT_RD;
		end
	end

	// memory ports
	always_comb begin
		jt_raddr = idx_q[SlotW-1:0];
		sq_raddr = (state_q == S_SHIFT_RD) ? HoldW'(idx_q - 1'b1) : idx_q[HoldW-1:0];
		sq_we = 1'b0;
		sq_waddr = idx_q[HoldW-1:0];
		sq_wdata = sq_rdata;
		if (state_q == S_SHIFT_WR) begin
			sq_we = 1'b1;
		end else if (state_q == S_SRT_INS) begin
			sq_we = 1'b1;
			sq_waddr = pos_q;
			sq_wdata.run_time = cmd_q.run_time;
			sq_wdata.slot = job_count_q[SlotW-1:0] - 1'b1;
		end
		jt_we = 1'b0;
		jt_waddr = job_count_q[SlotW-1:0];
		jt_wdata.id = cmd_q.job_id;
		jt_wdata.mem = cmd_q.mem_units;
		jt_wdata.demand = cmd_q.max_demand;
		jt_wdata.granted = 8'd0;
		jt_wdata.status = ST_NONE;
		fq_we = 1'b0;
		if (state_q == S_FINISH && cmd_q.req_type == REQ_NEW && !table_full) begin
			if (too_big) begin
				jt_we = 1'b1;
				jt_wdata.status = ST_REJECTED;
			end else if (fits) begin
				jt_we = 1'b1;
				jt_wdata.status = ST_READY;
			end else if (cmd_q.job_priority == PRI_SORTED) begin
				jt_we = (srt_len_q != CntW'(HoldDepth));
				jt_wdata.status = ST_HELD;
			end else if (cmd_q.job_priority == PRI_FIFO) begin
				jt_we = (fifo_len_q != CntW'(HoldDepth));
				fq_we = jt_we;
				jt_wdata.status = ST_HELD;
			end else begin
				jt_we = 1'b1;
			end
		end else if (state_q == S_FIND_CMP && id_match && cmd_q.req_type == REQ_DEVICE
			&& jt_rdata.status == ST_READY && jt_rdata.demand < avail_dev_q) begin
			// termination writes back the matched row
			jt_we = 1'b1;
			jt_waddr = idx_q[SlotW-1:0];
			jt_wdata = jt_rdata;
			jt_wdata.granted = grant;
			jt_wdata.status = ST_TERMINATED;
		end
	end

	// registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			total_mem_q <= '0;
			avail_mem_q <= '0;
			total_dev_q <= '0;
			avail_dev_q <= '0;
			job_count_q <= '0;
			srt_len_q <= '0;
			fifo_len_q <= '0;
			idx_q <= '0;
			done_q <= 1'b0;
			outcome_q <= OC_REQ_IGNORED;
			pos_q <= '0;
		end else begin
			state_q <= state_d;
			done_q <= 1'b0;
			if (cfg_we && state_q == S_IDLE) begin
				case (cfg_index)
					CFG_TOTAL_MEMORY: begin
						total_mem_q <= cfg_data;
						avail_mem_q <= cfg_data;
					end
					CFG_TOTAL_DEVICES: begin
						total_dev_q <= cfg_data[7:0];
						avail_dev_q <= cfg_data[7:0];
					end
					default: ;
				endcase
			end
			case (state_q)
				S_IDLE: begin
					if (take) begin
						idx_q <= '0;
						pos_q <= '0;
						outcome_q <= OC_REQ_IGNORED;
						cmd_q <= cmd;
						if (cmd.req_type == REQ_DEVICE || cmd.req_type == REQ_RELEASE) begin
							outcome_q <= OC_UNKNOWN_JOB;
						end
					end
				end
				S_FIND_RD: begin
					if (idx_q == job_count_q) begin
						done_q <= 1'b1;
					end
				end
				S_FIND_CMP: begin
					idx_q <= idx_q + 1'b1;
					if (id_match) begin
						done_q <= 1'b1;
						if (cmd_q.req_type == REQ_DEVICE) begin
							if (jt_rdata.status == ST_READY && jt_rdata.demand < avail_dev_q) begin
								outcome_q <= OC_GRANTED;
								avail_mem_q <= (mem_sum > {1'b0, total_mem_q})
									? total_mem_q : mem_sum[9:0];
								// grant returned at once, capped at total
								avail_dev_q <= (avail_dev_q > total_dev_q)
									? total_dev_q : avail_dev_q;
							end else begin
								outcome_q <= OC_REQ_IGNORED;
							end
						end else if (jt_rdata.status == ST_TERMINATED) begin
							outcome_q <= OC_RELEASED;
							avail_dev_q <= (dev_sum > {1'b0, total_dev_q})
								? total_dev_q : dev_sum[7:0];
						end else begin
							outcome_q <= OC_REL_IGNORED;
						end
					end
				end
				S_SRT_RD: begin
					if (idx_q == srt_len_q) begin
						pos_q <= idx_q[HoldW-1:0];
						idx_q <= srt_len_q;
					end
				end
				S_SRT_CMP: begin
					if (sq_rdata.run_time <= cmd_q.run_time) begin
						idx_q <= idx_q + 1'b1;
					end else begin
						pos_q <= idx_q[HoldW-1:0];
						idx_q <= srt_len_q;
					end
				end
				S_SHIFT_WR: idx_q <= idx_q - 1'b1;
				S_SRT_INS: begin
					srt_len_q <= srt_len_q + 1'b1;
					done_q <= 1'b1;
				end
				S_FINISH: begin
					if (cmd_q.req_type == REQ_NEW) begin
						if (table_full) begin
							outcome_q <= OC_TABLE_FULL;
							done_q <= 1'b1;
						end else if (too_big) begin
							outcome_q <= OC_REJECTED;
							job_count_q <= job_count_q + 1'b1;
							done_q <= 1'b1;
						end else if (fits) begin
							outcome_q <= OC_READY;
							avail_mem_q <= avail_mem_q - cmd_q.mem_units;
							job_count_q <= job_count_q + 1'b1;
							done_q <= 1'b1;
						end else if (cmd_q.job_priority == PRI_SORTED) begin
							if (srt_len_q == CntW'(HoldDepth)) begin
								outcome_q <= OC_TABLE_FULL;
								done_q <= 1'b1;
							end else begin
								outcome_q <= OC_HELD_SORTED;
								job_count_q <= job_count_q + 1'b1;
							end
						end else if (cmd_q.job_priority == PRI_FIFO) begin
							done_q <= 1'b1;
							if (fifo_len_q == CntW'(HoldDepth)) begin
								outcome_q <= OC_TABLE_FULL;
							end else begin
								outcome_q <= OC_HELD_FIFO;
								pos_q <= fifo_len_q[HoldW-1:0];
								fifo_len_q <= fifo_len_q + 1'b1;
								job_count_q <= job_count_q + 1'b1;
							end
						end else begin
							outcome_q <= OC_BAD_PRIORITY;
							job_count_q <= job_count_q + 1'b1;
							done_q <= 1'b1;
						end
					end else begin
						// unknown command
						outcome_q <= OC_REQ_IGNORED;
						done_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// outputs
	always_comb begin
		busy = (state_q != S_IDLE) || done_q;
		done = done_q;
		result.outcome = outcome_q;
		result.free_memory = avail_mem_q;
		result.free_devices = avail_dev_q;
		result.hold_sorted_count = srt_len_q;
		result.hold_fifo_count = fifo_len_q;
		result.hold_position = (outcome_q == OC_HELD_SORTED || outcome_q == OC_HELD_FIFO)
			? 5'(pos_q) : 5'd0;
	end

	logic unused_fq;
	assign unused_fq = ^fq_rdata;
endmodule
`default_nettype wire

FILE: design/jars_ram.sv
// generic single-port-write ram with registered read
`default_nettype none
module jars_ram #(
	parameter int Width = 8,
	parameter int Depth = 32
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(Depth)-1:0] waddr,
	input wire logic [Width-1:0] wdata,
	input wire logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire
